[rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the checker file.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled in reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[rtl/sclc_pkg.sv]
// ---------------------------------------------------------------------------
// sclc_pkg
// Sizes, record codes and the sequencer program of the cross-list compressor.
// ---------------------------------------------------------------------------
package sclc_pkg;

    localparam int MAX_ROWS    = 16;
    localparam int MAX_COLS    = 16;
    localparam int MAX_ENTRIES = 256;

    localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int WALK_W = (ROW_W > COL_W) ? ROW_W : COL_W;
    localparam int IDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);

    localparam int SIZE_W     = 5;
    localparam int DATA_W     = 32;
    localparam int KIND_W     = 3;
    localparam int TARGET_W   = 8;
    localparam int CFG_ADDR_W = 3;
    localparam int APB_W      = 32;
    localparam int PC_W       = 3;

    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(16);

    localparam logic REG_ROW_COUNT    = 1'b0;
    localparam logic REG_COLUMN_COUNT = 1'b1;

    typedef enum logic [KIND_W-1:0] {
        KIND_VALUE    = 3'd0,
        KIND_ROW_LINK = 3'd1,
        KIND_COL_LINK = 3'd2,
        KIND_ROW_HEAD = 3'd3,
        KIND_COL_HEAD = 3'd4,
        KIND_DONE     = 3'd5
    } kind_t;

    typedef enum logic [2:0] {
        EM_NONE,
        EM_VALUE,
        EM_ROW,
        EM_COL,
        EM_ROW_RING,
        EM_COL_RING,
        EM_DONE
    } emit_t;

    typedef enum logic [2:0] {
        C_ACCEPT,
        C_NEXT,
        C_STORE,
        C_LAST,
        C_WALK,
        C_JUMP
    } cond_t;

    localparam logic [PC_W-1:0] PC_FETCH    = 3'd0;
    localparam logic [PC_W-1:0] PC_DECIDE   = 3'd1;
    localparam logic [PC_W-1:0] PC_VALUE    = 3'd2;
    localparam logic [PC_W-1:0] PC_ROW      = 3'd3;
    localparam logic [PC_W-1:0] PC_COL      = 3'd4;
    localparam logic [PC_W-1:0] PC_ROW_RING = 3'd5;
    localparam logic [PC_W-1:0] PC_COL_RING = 3'd6;
    localparam logic [PC_W-1:0] PC_DONE     = 3'd7;

    typedef struct packed {
        logic            in_ready;
        emit_t           emit;
        cond_t           cond;
        logic [PC_W-1:0] target;
    } uword_t;

    typedef struct packed {
        logic accepted;
        logic store;
        logic last;
        logic walk_end;
        logic stall;
    } seq_stat_t;

    function automatic uword_t ucode(input logic [PC_W-1:0] pc);
        uword_t w;
        case (pc)
            PC_FETCH:    w = '{1'b1, EM_NONE,     C_ACCEPT, PC_FETCH};
            PC_DECIDE:   w = '{1'b0, EM_NONE,     C_STORE,  PC_ROW_RING};
            PC_VALUE:    w = '{1'b0, EM_VALUE,    C_NEXT,   PC_FETCH};
            PC_ROW:      w = '{1'b0, EM_ROW,      C_NEXT,   PC_FETCH};
            PC_COL:      w = '{1'b0, EM_COL,      C_LAST,   PC_FETCH};
            PC_ROW_RING: w = '{1'b0, EM_ROW_RING, C_WALK,   PC_FETCH};
            PC_COL_RING: w = '{1'b0, EM_COL_RING, C_WALK,   PC_FETCH};
            PC_DONE:     w = '{1'b0, EM_DONE,     C_JUMP,   PC_FETCH};
            default:     w = '{1'b1, EM_NONE,     C_ACCEPT, PC_FETCH};
        endcase
        return w;
    endfunction

endpackage

[rtl/sclc_if.sv]
// ---------------------------------------------------------------------------
// sclc_if
// Valid/ready channels for matrix elements in and write records out.
// ---------------------------------------------------------------------------
interface sclc_in_if import sclc_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] element_value;

    modport source (output valid, output element_value, input ready);
    modport sink   (input valid, input element_value, output ready);
endinterface

interface sclc_out_if import sclc_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [KIND_W-1:0]        record_kind;
    logic [TARGET_W-1:0]      target_index;
    logic signed [DATA_W-1:0] record_data;
    logic                     capacity_overflow;
    logic                     run_last;

    modport source (output valid, output record_kind, output target_index,
                    output record_data, output capacity_overflow, output run_last,
                    input ready);
    modport sink   (input valid, input record_kind, input target_index,
                    input record_data, input capacity_overflow, input run_last,
                    output ready);
endinterface

[rtl/sparse_cross_list_compressor.sv]
// ---------------------------------------------------------------------------
// sparse_cross_list_compressor
// Zero element: fetch, decide; nonzero adds value, row and column (a record each).
// Last element adds MAX_ROWS + MAX_COLS ring-walk steps and a done step.
// Rate is set by the microcoded step sequence; output stalls add cycles.
// Each record is registered and valid in the cycle after its step.
// Async active-low reset clears head flags, counters, positions; sizes reset to 16.
// ---------------------------------------------------------------------------
module sparse_cross_list_compressor import sclc_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [APB_W-1:0]      pwdata,
    output logic [APB_W-1:0]      prdata,
    output logic                  pready,
    sclc_in_if.sink               in_ch,
    sclc_out_if.source            out_ch
);

    uword_t    ctl;
    seq_stat_t stat;

    logic [SIZE_W-1:0] row_count_reg;
    logic [SIZE_W-1:0] column_count_reg;

    logic [DATA_W-1:0] value_reg;
    logic [ROW_W-1:0]  r_reg;
    logic [COL_W-1:0]  c_reg;
    logic              last_reg;
    logic [ROW_W-1:0]  row_pos_reg;
    logic [COL_W-1:0]  col_pos_reg;
    logic [CNT_W-1:0]  entry_count_reg;
    logic              overflow_reg;
    logic [WALK_W-1:0] walk_reg;

    logic [MAX_ROWS-1:0] row_head_valid_reg;
    logic [MAX_COLS-1:0] col_head_valid_reg;
    logic [IDX_W-1:0]    row_head_reg [MAX_ROWS];
    logic [IDX_W-1:0]    row_tail_reg [MAX_ROWS];
    logic [IDX_W-1:0]    col_head_reg [MAX_COLS];
    logic [IDX_W-1:0]    col_tail_reg [MAX_COLS];

    logic                out_valid_reg;
    logic [KIND_W-1:0]   kind_reg;
    logic [TARGET_W-1:0] target_reg;
    logic [DATA_W-1:0]   data_reg;
    logic                ovf_reg;
    logic                run_last_reg;

    logic [ROW_W:0]      rows;
    logic [COL_W:0]      cols;
    logic                row_end;
    logic                col_end;
    logic                last_cur;
    logic                accepted;
    logic                nonzero;
    logic                room;
    logic [IDX_W-1:0]    idx;
    logic [ROW_W-1:0]    walk_row;
    logic [COL_W-1:0]    walk_col;
    logic                emit_now;
    logic                stall;
    logic                advance;
    logic [KIND_W-1:0]   kind_c;
    logic [TARGET_W-1:0] target_c;
    logic [DATA_W-1:0]   data_c;
    logic                ovf_c;
    logic                run_last_c;
    logic                cfg_write;
    logic                cfg_sel;

    sclc_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctl   (ctl)
    );

    // APB
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_sel   = paddr[2];

    always_comb
    begin
        case (cfg_sel)
            REG_ROW_COUNT:    prdata = APB_W'(row_count_reg);
            REG_COLUMN_COUNT: prdata = APB_W'(column_count_reg);
            default:          prdata = '0;
        endcase
    end

    // sizes in use
    always_comb
    begin
        if (row_count_reg == '0)
            rows = (ROW_W+1)'(1);
        else if (32'(row_count_reg) > MAX_ROWS)
            rows = (ROW_W+1)'(MAX_ROWS);
        else
            rows = (ROW_W+1)'(row_count_reg);
        if (column_count_reg == '0)
            cols = (COL_W+1)'(1);
        else if (32'(column_count_reg) > MAX_COLS)
            cols = (COL_W+1)'(MAX_COLS);
        else
            cols = (COL_W+1)'(column_count_reg);
    end

    assign row_end  = ((ROW_W+1)'(row_pos_reg) + (ROW_W+1)'(1)) >= rows;
    assign col_end  = ((COL_W+1)'(col_pos_reg) + (COL_W+1)'(1)) >= cols;
    assign last_cur = row_end && col_end;

    assign in_ch.ready = ctl.in_ready;
    assign accepted    = in_ch.valid && ctl.in_ready;
    assign nonzero     = value_reg != '0;
    assign room        = entry_count_reg < CNT_W'(MAX_ENTRIES);
    assign idx         = entry_count_reg[IDX_W-1:0];
    assign walk_row    = walk_reg[ROW_W-1:0];
    assign walk_col    = walk_reg[COL_W-1:0];

    // record select
    always_comb
    begin
        emit_now   = 1'b0;
        kind_c     = KIND_VALUE;
        target_c   = '0;
        data_c     = '0;
        ovf_c      = 1'b0;
        run_last_c = 1'b0;
        case (ctl.emit)
            EM_VALUE:
            begin
                emit_now = 1'b1;
                kind_c   = KIND_VALUE;
                target_c = TARGET_W'(idx);
                data_c   = value_reg;
            end
            EM_ROW:
            begin
                emit_now = 1'b1;
                data_c   = DATA_W'(idx);
                if (row_head_valid_reg[r_reg])
                begin
                    kind_c   = KIND_ROW_LINK;
                    target_c = TARGET_W'(row_tail_reg[r_reg]);
                end
                else
                begin
                    kind_c   = KIND_ROW_HEAD;
                    target_c = TARGET_W'(r_reg);
                end
            end
            EM_COL:
            begin
                emit_now   = 1'b1;
                data_c     = DATA_W'(idx);
                run_last_c = !last_reg;
                if (col_head_valid_reg[c_reg])
                begin
                    kind_c   = KIND_COL_LINK;
                    target_c = TARGET_W'(col_tail_reg[c_reg]);
                end
                else
                begin
                    kind_c   = KIND_COL_HEAD;
                    target_c = TARGET_W'(c_reg);
                end
            end
            EM_ROW_RING:
            begin
                emit_now = row_head_valid_reg[walk_row];
                kind_c   = KIND_ROW_LINK;
                target_c = TARGET_W'(row_tail_reg[walk_row]);
                data_c   = DATA_W'(row_head_reg[walk_row]);
            end
            EM_COL_RING:
            begin
                emit_now = col_head_valid_reg[walk_col];
                kind_c   = KIND_COL_LINK;
                target_c = TARGET_W'(col_tail_reg[walk_col]);
                data_c   = DATA_W'(col_head_reg[walk_col]);
            end
            EM_DONE:
            begin
                emit_now   = 1'b1;
                kind_c     = KIND_DONE;
                data_c     = DATA_W'(entry_count_reg);
                ovf_c      = overflow_reg;
                run_last_c = 1'b1;
            end
            default:
            begin
                emit_now = 1'b0;
            end
        endcase
    end

    assign stall   = emit_now && out_valid_reg && !out_ch.ready;
    assign advance = !stall;

    assign stat.accepted = accepted;
    assign stat.store    = nonzero && room;
    assign stat.last     = last_reg;
    assign stat.walk_end = (ctl.emit == EM_ROW_RING) ?
                           (walk_reg == WALK_W'(MAX_ROWS - 1)) :
                           (walk_reg == WALK_W'(MAX_COLS - 1));
    assign stat.stall    = stall;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg      <= SIZE_RESET;
            column_count_reg   <= SIZE_RESET;
            row_pos_reg        <= '0;
            col_pos_reg        <= '0;
            entry_count_reg    <= '0;
            overflow_reg       <= 1'b0;
            walk_reg           <= '0;
            row_head_valid_reg <= '0;
            col_head_valid_reg <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_sel)
                    REG_ROW_COUNT:    row_count_reg    <= pwdata[SIZE_W-1:0];
                    REG_COLUMN_COUNT: column_count_reg <= pwdata[SIZE_W-1:0];
                    default:          row_count_reg    <= row_count_reg;
                endcase
            end

            if (accepted)
            begin
                if (last_cur)
                begin
                    row_pos_reg <= '0;
                    col_pos_reg <= '0;
                end
                else if (col_end)
                begin
                    row_pos_reg <= row_pos_reg + 1'b1;
                    col_pos_reg <= '0;
                end
                else
                begin
                    col_pos_reg <= col_pos_reg + 1'b1;
                end
            end

            if (ctl.cond == C_STORE && nonzero && !room)
                overflow_reg <= 1'b1;

            if (advance)
            begin
                case (ctl.emit)
                    EM_ROW:
                        row_head_valid_reg[r_reg] <= 1'b1;
                    EM_COL:
                    begin
                        col_head_valid_reg[c_reg] <= 1'b1;
                        entry_count_reg           <= entry_count_reg + 1'b1;
                    end
                    EM_ROW_RING, EM_COL_RING:
                        walk_reg <= stat.walk_end ? '0 : walk_reg + 1'b1;
                    EM_DONE:
                    begin
                        row_head_valid_reg <= '0;
                        col_head_valid_reg <= '0;
                        entry_count_reg    <= '0;
                        overflow_reg       <= 1'b0;
                    end
                    default:
                        walk_reg <= walk_reg;
                endcase
            end

            out_valid_reg <= (emit_now && advance) || (out_valid_reg && !out_ch.ready);
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (accepted)
        begin
            value_reg <= in_ch.element_value;
            r_reg     <= row_pos_reg;
            c_reg     <= col_pos_reg;
            last_reg  <= last_cur;
        end
        if (advance && ctl.emit == EM_ROW)
        begin
            if (!row_head_valid_reg[r_reg])
                row_head_reg[r_reg] <= idx;
            row_tail_reg[r_reg] <= idx;
        end
        if (advance && ctl.emit == EM_COL)
        begin
            if (!col_head_valid_reg[c_reg])
                col_head_reg[c_reg] <= idx;
            col_tail_reg[c_reg] <= idx;
        end
        if (emit_now && advance)
        begin
            kind_reg     <= kind_c;
            target_reg   <= target_c;
            data_reg     <= data_c;
            ovf_reg      <= ovf_c;
            run_last_reg <= run_last_c;
        end
    end

    assign out_ch.valid             = out_valid_reg;
    assign out_ch.record_kind       = kind_reg;
    assign out_ch.target_index      = target_reg;
    assign out_ch.record_data       = data_reg;
    assign out_ch.capacity_overflow = ovf_reg;
    assign out_ch.run_last          = run_last_reg;

endmodule

[rtl/sclc_seq.sv]
// ---------------------------------------------------------------------------
// sclc_seq
// Step counter over the control ROM, with conditional jumps on datapath status.
// ---------------------------------------------------------------------------
module sclc_seq import sclc_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  seq_stat_t stat,
    output uword_t    ctl
);

    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;

    assign ctl = ucode(pc_reg);

    always_comb
    begin
        pc_next = pc_reg;
        if (!stat.stall)
        begin
            case (ctl.cond)
                C_ACCEPT: pc_next = stat.accepted ? pc_reg + 1'b1 : pc_reg;
                C_NEXT:   pc_next = pc_reg + 1'b1;
                C_STORE:
                begin
                    if (stat.store)
                        pc_next = pc_reg + 1'b1;
                    else
                        pc_next = stat.last ? ctl.target : PC_FETCH;
                end
                C_LAST:   pc_next = stat.last ? pc_reg + 1'b1 : PC_FETCH;
                C_WALK:   pc_next = stat.walk_end ? pc_reg + 1'b1 : pc_reg;
                C_JUMP:   pc_next = ctl.target;
                default:  pc_next = PC_FETCH;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pc_reg <= PC_FETCH;
        else
            pc_reg <= pc_next;
    end

endmodule

[rtl/sclc_chk.sv]
// ---------------------------------------------------------------------------
// sclc_chk
// Port-level checks on the record stream, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sclc_chk import sclc_pkg::*; (
    input logic                clk,
    input logic                rst_n,
    input logic                out_valid,
    input logic                out_ready,
    input logic [KIND_W-1:0]   record_kind,
    input logic [TARGET_W-1:0] target_index,
    input logic [DATA_W-1:0]   record_data,
    input logic                capacity_overflow,
    input logic                run_last
);

    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(record_kind) && $stable(record_data) && $stable(target_index))
    `ASSERT_IMPL(a_done_last, clk, rst_n, out_valid && record_kind == KIND_DONE, run_last && target_index == '0)
    `ASSERT_IMPL(a_ovf_done, clk, rst_n, out_valid && capacity_overflow, record_kind == KIND_DONE)
    `ASSERT_IMPL(a_value_nz, clk, rst_n, out_valid && record_kind == KIND_VALUE, record_data != '0 && !run_last)

endmodule

bind sparse_cross_list_compressor sclc_chk u_chk (
    .clk               (clk),
    .rst_n             (rst_n),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .record_kind       (out_ch.record_kind),
    .target_index      (out_ch.target_index),
    .record_data       (out_ch.record_data),
    .capacity_overflow (out_ch.capacity_overflow),
    .run_last          (out_ch.run_last)
);
